@@ rtl/core/spq_pkg.sv @@
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned URG_LOW  = 1;
  localparam int unsigned URG_HIGH = 5;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_SORT = 1'b1;

  localparam logic [1:0] STATUS_ENTRY = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic        op;
    logic [15:0] patient_tag;
    logic [7:0]  age;
    logic [2:0]  urgency;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  position;
    logic [15:0] out_tag;
    logic [7:0]  out_age;
    logic [2:0]  out_urgency;
    logic        last;
  } out_item_t;

  // one stored entry; arrival order is the storage address
  typedef struct packed {
    logic [2:0]  urgency;
    logic [7:0]  age;
    logic [15:0] tag;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STATUS,
    ST_READ,
    ST_CHECK
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic       wr_en;
    logic       set_status;
    logic [1:0] status_code;
    logic       scan_start;
    logic       rd_en;
    logic       adv;
    logic       load_entry;
    logic       load_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic has_space;
    logic is_empty;
    logic match;
    logic last_hit;
    logic out_free;
  } sts_t;

  function automatic logic [2:0] norm_urgency(input logic [2:0] urg);
    logic [2:0] res;
    if (urg < 3'(URG_LOW) || urg > 3'(URG_HIGH)) begin
      res = 3'(URG_LOW);
    end else begin
      res = urg;
    end
    return res;
  endfunction

endpackage

@@ rtl/core/spq_ram.sv @@
`timescale 1ns / 1ps

module spq_ram #(
  parameter int unsigned WIDTH = 27,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/spq_ctrl.sv @@
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_op_i,
  output logic          in_stall_o,
  input  spq_pkg::sts_t sts_i,
  output spq_pkg::cmd_t cmd_o
);

  spq_pkg::state_e state_q, state_d;
  logic            accept;

  assign in_stall_o = (state_q != spq_pkg::ST_IDLE);
  assign accept     = in_valid_i && (state_q == spq_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      spq_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_op_i == spq_pkg::OP_ADD) begin
            if (!sts_i.has_space) begin
              state_d = spq_pkg::ST_STATUS;
            end
          end else if (sts_i.is_empty) begin
            state_d = spq_pkg::ST_STATUS;
          end else begin
            state_d = spq_pkg::ST_READ;
          end
        end
      end
      spq_pkg::ST_STATUS: begin
        if (sts_i.out_free) begin
          state_d = spq_pkg::ST_IDLE;
        end
      end
      spq_pkg::ST_READ: begin
        state_d = spq_pkg::ST_CHECK;
      end
      spq_pkg::ST_CHECK: begin
        if (!sts_i.match) begin
          state_d = spq_pkg::ST_READ;
        end else if (sts_i.out_free) begin
          state_d = sts_i.last_hit ? spq_pkg::ST_IDLE : spq_pkg::ST_READ;
        end
      end
      default: begin
        state_d = spq_pkg::ST_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      spq_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_op_i == spq_pkg::OP_ADD) begin
            if (sts_i.has_space) begin
              cmd_o.wr_en = 1'b1;
            end else begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = spq_pkg::STATUS_FULL;
            end
          end else if (sts_i.is_empty) begin
            cmd_o.set_status  = 1'b1;
            cmd_o.status_code = spq_pkg::STATUS_EMPTY;
          end else begin
            cmd_o.scan_start = 1'b1;
          end
        end
      end
      spq_pkg::ST_STATUS: begin
        cmd_o.load_status = sts_i.out_free;
      end
      spq_pkg::ST_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      spq_pkg::ST_CHECK: begin
        if (!sts_i.match) begin
          cmd_o.adv = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.load_entry = 1'b1;
          cmd_o.adv        = 1'b1;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

@@ rtl/core/spq_dpath.sv @@
`timescale 1ns / 1ps

module spq_dpath #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::in_item_t   in_item_i,
  input  logic [5:0]          limit_i,
  input  spq_pkg::cmd_t       cmd_i,
  output spq_pkg::sts_t       sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output spq_pkg::out_item_t  out_item_o
);

  localparam int unsigned AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMPW = (CW > 6) ? CW : 6;
  localparam int unsigned ENTRY_WL = spq_pkg::ENTRY_W;

  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      emit_q, emit_d;
  logic [AW-1:0]      addr_q, addr_d;
  logic [2:0]         urg_q, urg_d;
  logic [1:0]         status_q;
  logic               out_valid_q, out_valid_d;
  spq_pkg::out_item_t out_item_q, out_item_d;

  spq_pkg::entry_t    wr_entry, rd_entry;
  logic [ENTRY_WL-1:0] rd_word;

  logic [CMPW-1:0]    cnt_ext, lim_ext, pos_ext;
  logic               pass_end;

  assign wr_entry.tag     = in_item_i.patient_tag;
  assign wr_entry.age     = in_item_i.age;
  assign wr_entry.urgency = spq_pkg::norm_urgency(in_item_i.urgency);

  spq_ram #(
    .WIDTH (ENTRY_WL),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.rd_en),
    .raddr_i (addr_q),
    .rdata_o (rd_word)
  );

  assign rd_entry = spq_pkg::entry_t'(rd_word);

  assign cnt_ext = CMPW'(count_q);
  assign lim_ext = CMPW'(limit_i);
  assign pos_ext = CMPW'(emit_q) + CMPW'(1);

  assign pass_end = (CW'(addr_q) == count_q - CW'(1));

  assign sts_o.has_space = (cnt_ext < lim_ext) && (cnt_ext < CMPW'(MAX_ENTRIES));
  assign sts_o.is_empty  = (count_q == '0);
  assign sts_o.match     = (rd_entry.urgency == urg_q);
  assign sts_o.last_hit  = ((emit_q + CW'(1)) == count_q);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    count_d = count_q;
    emit_d  = emit_q;
    addr_d  = addr_q;
    urg_d   = urg_q;
    if (cmd_i.wr_en) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.scan_start) begin
      emit_d = '0;
      addr_d = '0;
      urg_d  = 3'(spq_pkg::URG_HIGH);
    end
    if (cmd_i.adv) begin
      if (pass_end) begin
        addr_d = '0;
        urg_d  = urg_q - 3'd1;
      end else begin
        addr_d = addr_q + AW'(1);
      end
    end
    if (cmd_i.load_entry) begin
      emit_d = emit_q + CW'(1);
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    if (cmd_i.load_entry) begin
      out_valid_d            = 1'b1;
      out_item_d.status      = spq_pkg::STATUS_ENTRY;
      out_item_d.position    = pos_ext[5:0];
      out_item_d.out_tag     = rd_entry.tag;
      out_item_d.out_age     = rd_entry.age;
      out_item_d.out_urgency = rd_entry.urgency;
      out_item_d.last        = sts_o.last_hit;
    end else if (cmd_i.load_status) begin
      out_valid_d            = 1'b1;
      out_item_d.status      = status_q;
      out_item_d.position    = '0;
      out_item_d.out_tag     = '0;
      out_item_d.out_age     = '0;
      out_item_d.out_urgency = '0;
      out_item_d.last        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    emit_q     <= emit_d;
    addr_q     <= addr_d;
    urg_q      <= urg_d;
    out_item_q <= out_item_d;
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status_code;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ rtl/core/stable_priority_queue_sort_core.sv @@
`timescale 1ns / 1ps
// Stable priority queue: entries are added one per transfer and, on a sort
// transfer, streamed out by urgency (5 first) and arrival order on ties.
// Input channel: in_valid_i / in_stall_o with in_item_i (op, tag, age,
// urgency). Output channel: out_valid_o / out_stall_i with out_item_o.
// An add that fits is taken on its transfer and gives no result; adds keep
// flowing while an earlier result waits in the output register. A refused
// add (count not below queue_limit or MAX_ENTRIES) or a sort of an empty
// queue gives one status result, loaded from the ST_STATUS state. A sort
// scans the entry RAM once per urgency level, 5 down to 1; each stored entry
// visited is read from the RAM (ST_READ), then compared (ST_CHECK), and the
// scan stops at the last emitted entry. The input stalls until the sort
// finishes. When the receiver stalls, the output register holds its result
// and the scan waits on it. Reset clears the entry count and the output
// valid, and sets queue_limit (APB offset 0) to 32; RAM content is left as is.
module stable_priority_queue_sort_core #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  spq_pkg::in_item_t  in_item_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output spq_pkg::out_item_t out_item_o
);

  logic [5:0]    limit_q;
  logic          cfg_wr;
  logic [1:0]    unused_addr;
  spq_pkg::cmd_t cmd;
  spq_pkg::sts_t sts;

  // single register: every word offset within the decode hits queue_limit
  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite;
  assign unused_addr = paddr;
  assign prdata      = {26'd0, limit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 6'd32;
    end else if (cfg_wr && (unused_addr == unused_addr)) begin
      limit_q <= pwdata[5:0];
    end
  end

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_item_i.op),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spq_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .limit_i     (limit_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
